### src/sha256_hash_engine_defines.svh
// Assertion macros for the SHA-256 hash engine checker.
// Used only by files that assert; no other dependencies.
`ifndef SHA256_HASH_ENGINE_DEFINES_SVH
`define SHA256_HASH_ENGINE_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SHE_ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the engine clock and reset.
`define SHE_ASSERT(lbl, prop, msg) \
    `SHE_ASSERT_AT(lbl, aclk, aresetn, prop, msg)

`endif

### src/she_pkg.sv
// Shared types, constants and round functions of the SHA-256 hash engine.
// No dependencies; imported by the top level and its checker.
package she_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_DONE
    } she_state_t;

    typedef enum logic {
        CMD_ABSORB = 1'b0,
        CMD_FINISH = 1'b1
    } she_cmd_t;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } she_in_t;

    typedef struct packed {
        logic [63:0] digest_word_0;
        logic [63:0] digest_word_1;
        logic [63:0] digest_word_2;
        logic [63:0] digest_word_3;
    } she_out_t;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

### src/sha256_hash_engine.sv
// SHA-256 hash engine top level: byte absorb, padding sequencer, round unit.
// Depends on she_pkg for beat types, round constants and sigma functions.
//
// Feed the message one byte per input beat with command = 0, then send one
// beat with command = 1 to pad and finish; that beat alone yields a result
// beat holding the 256-bit digest as four 64-bit words, most significant
// first, after which the engine is ready for a new message. The byte that
// completes a 64-byte block is followed by the round unit (one round a
// cycle, shared by all rounds and carrying the message schedule in the
// block register) and a fold of the working words into the hash, with
// s_ready low throughout. A finish beat then shifts in the pad byte, zeros
// and the length one byte a cycle up to the block end, runs one or two
// compressions, and loads the result register, later if the previous
// digest has not yet left the result register. The result register frees
// the output side: absorb beats are taken while a digest waits, and only
// the loading of a further digest waits for m_ready.
module sha256_hash_engine
    import she_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  she_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output she_out_t m_data
);

    she_state_t  state_reg, state_next;
    logic [31:0] hash_reg [8];
    logic [31:0] hash_next [8];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [511:0] blk_reg, blk_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] count_reg, count_next;
    logic [63:0] len_reg, len_next;
    logic [5:0]  round_reg, round_next;
    logic        pad_reg, pad_next;
    logic        ovf_reg, ovf_next;
    logic        m_valid_reg, m_valid_next;
    she_out_t    m_data_reg, m_data_next;

    // Round unit: word window sits in blk_reg, oldest word at the top.
    logic [31:0] w_cur, w_new, t1, t2, ch, maj;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        w_cur = blk_reg[511:480];
        w_new = w_cur + small_sigma0(blk_reg[479:448]) + blk_reg[223:192]
              + small_sigma1(blk_reg[63:32]);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1    = v_reg[7] + big_sigma1(v_reg[4]) + ch + ROUND_K[round_reg] + w_cur;
        t2    = big_sigma0(v_reg[0]) + maj;
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (fill_reg == FILL_LAST) begin
                        state_next = ST_ROUND;
                    end else if (s_data.command == CMD_FINISH) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (fill_reg == FILL_LAST) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (round_reg == ROUND_LAST) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (!pad_reg) begin
                    state_next = ST_IDLE;
                end else if (ovf_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs and datapath next values.
    always_comb begin
        s_ready      = 1'b0;
        hash_next    = hash_reg;
        v_next       = v_reg;
        blk_next     = blk_reg;
        fill_next    = fill_reg;
        count_next   = count_reg;
        len_next     = len_reg;
        round_next   = round_reg;
        pad_next     = pad_reg;
        ovf_next     = ovf_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    fill_next = fill_reg + 6'd1;
                    if (s_data.command == CMD_FINISH) begin
                        // Latch the bit length, append the pad byte.
                        blk_next = {blk_reg[503:0], PAD_BYTE};
                        len_next = {count_reg, 3'b000};
                        pad_next = 1'b1;
                        ovf_next = (fill_reg >= LEN_POS);
                    end else begin
                        blk_next   = {blk_reg[503:0], s_data.data_byte};
                        count_next = count_reg + 61'd1;
                    end
                end
            end
            ST_PAD: begin
                fill_next = fill_reg + 6'd1;
                if (ovf_reg || (fill_reg < LEN_POS)) begin
                    blk_next = {blk_reg[503:0], 8'h00};
                end else begin
                    // Length field, most significant byte first.
                    blk_next = {blk_reg[503:0], len_reg[63:56]};
                    len_next = {len_reg[55:0], 8'h00};
                end
            end
            ST_ROUND: begin
                v_next[7]  = v_reg[6];
                v_next[6]  = v_reg[5];
                v_next[5]  = v_reg[4];
                v_next[4]  = v_reg[3] + t1;
                v_next[3]  = v_reg[2];
                v_next[2]  = v_reg[1];
                v_next[1]  = v_reg[0];
                v_next[0]  = t1 + t2;
                blk_next   = {blk_reg[479:0], w_new};
                round_next = round_reg + 6'd1;
            end
            ST_FOLD: begin
                for (int i = 0; i < 8; i++) begin
                    hash_next[i] = hash_reg[i] + v_reg[i];
                end
                // Overflow block done: length goes in the next one.
                ovf_next = 1'b0;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_data_next.digest_word_0  = {hash_reg[0], hash_reg[1]};
                    m_data_next.digest_word_1  = {hash_reg[2], hash_reg[3]};
                    m_data_next.digest_word_2  = {hash_reg[4], hash_reg[5]};
                    m_data_next.digest_word_3  = {hash_reg[6], hash_reg[7]};
                    hash_next                  = H_INIT;
                    count_next                 = '0;
                    pad_next                   = 1'b0;
                end
            end
            default: ;
        endcase

        // Entering the rounds: load working words, restart the counter.
        if ((state_next == ST_ROUND) && (state_reg != ST_ROUND)) begin
            v_next     = hash_next;
            round_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            hash_reg    <= H_INIT;
            fill_reg    <= '0;
            count_reg   <= '0;
            pad_reg     <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hash_reg    <= hash_next;
            fill_reg    <= fill_next;
            count_reg   <= count_next;
            pad_reg     <= pad_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg      <= v_next;
        blk_reg    <= blk_next;
        len_reg    <= len_next;
        round_reg  <= round_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### src/she_checker.sv
// Port-level checker for the SHA-256 hash engine, bound to the top level.
// Depends on she_pkg and sha256_hash_engine_defines.svh.
`include "sha256_hash_engine_defines.svh"

module she_checker
    import she_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input she_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input she_out_t m_data
);

    // Hold a stalled result beat.
    `SHE_ASSERT(a_result_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result beat changed while stalled")

    // A finish beat always starts padding or a compression, so input drops.
    `SHE_ASSERT(a_finish_busy, s_valid && s_ready && (s_data.command == CMD_FINISH) |=> !s_ready, "input still ready after finish beat")

    // A new result only appears after a busy cycle.
    `SHE_ASSERT(a_result_after_busy, $rose(m_valid) |-> $past(!s_ready), "result raised without preceding work")

    // Loading the result returns the engine to accepting input.
    `SHE_ASSERT(a_ready_with_result, $rose(m_valid) |-> s_ready, "engine not ready when result raised")

endmodule

bind sha256_hash_engine she_checker u_she_checker (.*);
